// ----- hw/rtl/ttrc_pkg.sv -----
// Package for the three-term recurrence checksum block.
// Holds the recurrence constants and the modulo-65535 fold functions.
// No dependencies.
`default_nettype none

package ttrc_pkg;

    // Index multipliers for the alpha and beta coefficients
    localparam logic [7:0]  ALPHA_MULT  = 8'd17;
    localparam logic [7:0]  BETA_MULT   = 8'd31;

    // Seed values for the first byte of a message
    localparam logic [8:0]  SEED_OFFSET = 9'd7;
    localparam logic [15:0] SEED_PREV   = 16'd1;
    localparam logic [7:0]  SEED_INDEX  = 8'd1;

    // Fold modulus; a reduced term never takes this value
    localparam logic [15:0] FOLD_MOD    = 16'hFFFF;

    // Reduce a 17-bit value below 66047 modulo 65535
    function automatic logic [15:0] fold_mod17(input logic [16:0] val);
        logic [15:0] sum;
        sum = 16'(val[16]) + val[15:0];
        return (sum == FOLD_MOD) ? 16'd0 : sum;
    endfunction

    // Reduce a 25-bit value modulo 65535 (2^16 is congruent to 1)
    function automatic logic [15:0] fold_mod25(input logic [24:0] val);
        logic [16:0] sum;
        sum = 17'(val[24:16]) + 17'(val[15:0]);
        return fold_mod17(sum);
    endfunction

endpackage : ttrc_pkg

`default_nettype wire

// ----- hw/rtl/ttrc_step.sv -----
// One continuation step of the recurrence: next term from byte, index and
// the two previous terms, reduced modulo 65535. Uses ttrc_pkg.
`default_nettype none

module ttrc_step
    import ttrc_pkg::*;
(
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  byte_index,
    input  wire logic [15:0] cur_term,
    input  wire logic [15:0] prev_term,
    output logic      [15:0] next_term
);

    logic [15:0] alpha_prod;
    logic [15:0] beta_prod;
    logic [8:0]  factor;
    logic [24:0] prod;
    logic [24:0] sub;
    logic        neg;
    logic [24:0] mag;
    logic [15:0] mag_mod;
    logic [16:0] neg_sum;

    // Coefficients: keep the low byte of index times constant
    assign alpha_prod = 16'(byte_index) * 16'(ALPHA_MULT);
    assign beta_prod  = 16'(byte_index) * 16'(BETA_MULT);
    assign factor     = 9'(data_byte) + 9'(alpha_prod[7:0]);

    // Two narrow products
    assign prod = 25'(factor) * 25'(cur_term);
    assign sub  = 25'(beta_prod[7:0]) * 25'(prev_term);

    // Difference magnitude and its residue
    assign neg     = (prod < sub);
    assign mag     = neg ? (sub - prod) : (prod - sub);
    assign mag_mod = fold_mod25(mag);

    // A wrapped 64-bit difference folds to (1 - residue) mod 65535
    assign neg_sum   = 17'h10000 - 17'(mag_mod);
    assign next_term = neg ? fold_mod17(neg_sum) : mag_mod;

endmodule : ttrc_step

`default_nettype wire

// ----- hw/rtl/three_term_recurrence_checksum_top.sv -----
// Three-term recurrence checksum: an accepted last byte leaving the input
// register loads the checksum into the output register; throughput one byte per
// cycle while the input is not stalled, since the recurrence update (two narrow
// multiplies and a fold) is combinational. The output register frees the input
// side unless it holds an untaken checksum and another last byte waits behind it.
// Asynchronous active-low reset empties both registers and starts a new message.
`default_nettype none

module three_term_recurrence_checksum_top
    import ttrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] checksum
);

    logic        in_valid_reg,  in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] checksum_reg;
    logic [15:0] prev_term_reg, prev_term_next;
    logic [15:0] cur_term_reg,  cur_term_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic        in_message_reg, in_message_next;
    logic        in_fire;
    logic        advance;
    logic [15:0] step_term;

    // Move the held beat on unless it is a last byte facing a full, stalled output
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    ttrc_step u_step (
        .data_byte  (in_byte_reg),
        .byte_index (byte_index_reg),
        .cur_term   (cur_term_reg),
        .prev_term  (prev_term_reg),
        .next_term  (step_term)
    );

    // Recurrence state update
    always_comb
    begin
        prev_term_next  = prev_term_reg;
        cur_term_next   = cur_term_reg;
        byte_index_next = byte_index_reg;
        in_message_next = in_message_reg;
        if (advance)
        begin
            if (!in_message_reg)
            begin
                prev_term_next  = SEED_PREV;
                cur_term_next   = 16'(9'(in_byte_reg) + SEED_OFFSET);
                byte_index_next = SEED_INDEX;
            end
            else
            begin
                prev_term_next  = cur_term_reg;
                cur_term_next   = step_term;
                byte_index_next = byte_index_reg + 8'd1;
            end
            in_message_next = !in_last_reg;
        end
    end

    // Input and output valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_term_reg  <= 16'd0;
            cur_term_reg   <= 16'd0;
            byte_index_reg <= 8'd0;
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            prev_term_reg  <= prev_term_next;
            cur_term_reg   <= cur_term_next;
            byte_index_reg <= byte_index_next;
            in_message_reg <= in_message_next;
        end
    end

    // Payload registers: capture the beat, load the checksum on a last byte
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (advance && in_last_reg)
            checksum_reg <= cur_term_next;
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

    // A reduced term never equals the modulus
    a_checksum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (checksum_reg != FOLD_MOD))
        else $error("checksum not reduced modulo 65535");

    a_term_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        in_message_reg |-> (cur_term_reg != FOLD_MOD))
        else $error("current term not reduced modulo 65535");

    // Stall only with a last byte held behind a waiting checksum
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && in_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked last byte");

    // A first byte that is not last seeds the index and opens a message
    a_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_message_reg && !in_last_reg)
            |=> (in_message_reg && (byte_index_reg == SEED_INDEX)
                 && (prev_term_reg == SEED_PREV)))
        else $error("message seed not applied");

endmodule : three_term_recurrence_checksum_top

`default_nettype wire

// ----- dv/tb_three_term_recurrence_checksum_top.sv -----
// Testbench for three_term_recurrence_checksum_top: byte streams in, checksums out.
// Predicts each checksum in-line and checks every output beat against it.
// Depends on hw/rtl/ttrc_pkg.sv and hw/rtl/three_term_recurrence_checksum_top.sv.
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum_top
    import ttrc_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] checksum;

    // Recurrence state mirrored from the block
    logic [15:0] rec_prev = 16'd0;
    logic [15:0] rec_cur = 16'd0;
    logic [7:0]  rec_index = 8'd0;
    logic        rec_open = 1'b0;

    logic [15:0] pending_sums[$];

    // Traffic controls, changed only by nonblocking assignment at a clock edge
    logic        no_idle = 1'b0;
    logic        stall_hold = 1'b0;

    int          fail_count = 0;
    int          beats_sent = 0;
    int          sums_checked = 0;
    int          msg_len = 0;
    int          longest_msg = 0;
    int          cycle_count = 0;

    three_term_recurrence_checksum_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .checksum  (checksum)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d checksums outstanding",
                     cycle_count, pending_sums.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Advance the recurrence by one accepted byte; queue the checksum on a last byte
    task automatic advance_recurrence(input logic [7:0] b, input logic lst);
        logic [7:0]  alpha;
        logic [7:0]  beta;
        logic [63:0] prod;
        logic [63:0] sub;
        logic [63:0] diff;
        if (!rec_open)
        begin
            rec_prev  = 16'd1;
            rec_cur   = 16'(b) + 16'd7;
            rec_index = 8'd1;
            rec_open  = 1'b1;
            msg_len   = 1;
        end
        else
        begin
            alpha = rec_index * ALPHA_MULT;
            beta  = rec_index * BETA_MULT;
            prod  = (64'(b) + 64'(alpha)) * 64'(rec_cur);
            sub   = 64'(beta) * 64'(rec_prev);
            // Unsigned wrap on a negative difference is intended
            diff  = prod - sub;
            rec_prev  = rec_cur;
            rec_cur   = 16'(diff % 64'd65535);
            rec_index = rec_index + 8'd1;
            msg_len   = msg_len + 1;
        end
        if (lst)
        begin
            pending_sums.push_back(rec_cur);
            rec_open = 1'b0;
            if (msg_len > longest_msg)
                longest_msg = msg_len;
        end
    endtask

    // Offer one beat, idling first at random, and hold it until accepted
    task automatic send_beat(input logic [7:0] b, input logic lst);
        while (!no_idle && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (in_stall);
        advance_recurrence(b, lst);
        beats_sent++;
    endtask

    // Send a whole message of random bytes; fill selects all-zero or all-ones content
    task automatic send_message(input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                1:       b = 8'h00;
                2:       b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_beat(b, (i == len - 1));
        end
    endtask

    // Receiver: stall about a quarter of the cycles, solidly during a hold-off, never in no-idle traffic
    always @(posedge clk)
    begin
        if (stall_hold)
            out_stall <= 1'b1;
        else if (no_idle)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 24);
    end

    // Check each accepted checksum against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("checksum: unexpected beat, actual %0d", checksum);
                fail_count++;
            end
            else
            begin
                if (checksum !== pending_sums[0])
                begin
                    $error("checksum: expected %0d actual %0d", pending_sums[0], checksum);
                    fail_count++;
                end
                void'(pending_sums.pop_front());
                sums_checked++;
            end
        end
    end

    // Single-byte messages at the byte extremes and two alternating patterns
    task automatic test_single_byte();
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h55, 1'b1);
        send_beat(8'hAA, 1'b1);
    endtask

    // Short messages with extreme and mixed content
    task automatic test_short_messages();
        send_message(2, 1);
        send_message(2, 2);
        send_message(3, 2);
        send_message(4, 1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h01, 1'b1);
        send_message(5, 0);
    endtask

    // Long message that wraps the byte index past 255
    task automatic test_index_wrap();
        send_message($urandom_range(257, 264), 0);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_no_idle();
        no_idle <= 1'b1;
        for (int n = 0; n < 40; n++)
            send_message($urandom_range(1, 4), 0);
        no_idle <= 1'b0;
    endtask

    // Hold off the receiver while short messages keep arriving
    task automatic test_backpressure();
        fork
            begin
                stall_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_hold <= 1'b0;
            end
        join_none
        for (int n = 0; n < 40; n++)
            send_message($urandom_range(1, 2), 0);
    endtask

    // Mostly short random messages, some longer ones and some flat content
    task automatic test_random_messages(input int beat_budget);
        int start;
        int len;
        int fill;
        start = beats_sent;
        while (beats_sent - start < beat_budget)
        begin
            if ($urandom_range(99) < 10)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(1, 12);
            fill = ($urandom_range(99) < 8) ? $urandom_range(1, 2) : 0;
            send_message(len, fill);
        end
    endtask

    initial
    begin
        // Hold reset low, then release it at an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte();
        test_short_messages();
        test_index_wrap();
        test_random_messages(150);
        test_no_idle();
        test_backpressure();
        test_random_messages(150);

        in_valid <= 1'b0;
        last_byte <= 1'b0;

        // Drain outstanding checksums, then let the pipeline settle
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes, checked %0d checksums, longest message %0d bytes",
                 beats_sent, sums_checked, longest_msg);
        $display("covered single-byte and index-wrap messages, idle gaps and a long hold-off");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ttrc_pkg.sv
hw/rtl/ttrc_step.sv
hw/rtl/three_term_recurrence_checksum_top.sv
dv/tb_three_term_recurrence_checksum_top.sv
